>>> src/ihex_pkg.sv
// Shared types, codes and the hex digit decoder for the HEX record parser.
`timescale 1ns / 1ps
`default_nettype none
package ihex_pkg;

  // Field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;

  // Characters of note
  localparam logic [CharW-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CharW-1:0] CHAR_UC_F  = 8'h46;
  localparam logic [CharW-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CharW-1:0] CHAR_LC_F  = 8'h66;

  // Record types
  localparam logic [ByteW-1:0] REC_DATA = 8'h00;
  localparam logic [ByteW-1:0] REC_EOF  = 8'h01;

  // Event codes
  localparam logic [KindW-1:0] EV_WRITE     = 3'd0;
  localparam logic [KindW-1:0] EV_OK        = 3'd1;
  localparam logic [KindW-1:0] EV_CSUM_ERR  = 3'd2;
  localparam logic [KindW-1:0] EV_EOF       = 3'd3;
  localparam logic [KindW-1:0] EV_MALFORMED = 3'd4;

  // Parse phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_COUNT   = 7'b0000010,
    PH_ADDR_HI = 7'b0000100,
    PH_ADDR_LO = 7'b0001000,
    PH_TYPE    = 7'b0010000,
    PH_DATA    = 7'b0100000,
    PH_CSUM    = 7'b1000000
  } ihex_phase_t;

  // One result from the parser towards the output register
  typedef struct packed {
    logic             vld;
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] rkind;
  } ihex_res_t;

  // Digit value in the low four bits; top bit set when not a hex digit
  function automatic logic [NibW:0] hex_value(input logic [CharW-1:0] c);
    logic [NibW:0] v;
    v = {1'b1, {NibW{1'b0}}};
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = {1'b0, c[NibW-1:0]};
    end else if ((c >= CHAR_UC_A && c <= CHAR_UC_F) || (c >= CHAR_LC_A && c <= CHAR_LC_F)) begin
      // 'A'/'a' have low nibble 1, so add 9 to reach 10
      v = {1'b0, c[NibW-1:0] + 4'd9};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/ihex_in_stage.sv
// Input register for the character request channel.
`timescale 1ns / 1ps
`default_nettype none
module ihex_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [ihex_pkg::CharW-1:0] in_char,
  input  wire logic                       adv,
  output logic                            hold_vld,
  output logic [ihex_pkg::CharW-1:0]      hold_char
);
  import ihex_pkg::*;

  logic             vld_r, vld_nxt;
  logic [CharW-1:0] char_r;
  logic             take;

  // Full register stalls unless it drains this cycle
  assign in_stall = vld_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Character payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      char_r <= in_char;
    end
  end

  assign hold_vld  = vld_r;
  assign hold_char = char_r;
endmodule
`default_nettype wire

>>> src/ihex_parser.sv
// Record state machine: decodes one character per cycle while adv is high and forms events.
`timescale 1ns / 1ps
`default_nettype none
module ihex_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic [ihex_pkg::CharW-1:0] char_in,
  output ihex_pkg::ihex_res_t             res
);
  import ihex_pkg::*;

  ihex_phase_t      phase_r, phase_nxt;
  logic [NibW-1:0]  high_r, high_nxt;
  logic             half_r, half_nxt;
  logic [ByteW-1:0] left_r, left_nxt;
  logic [AddrW-1:0] addr_r, addr_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;
  logic [ByteW-1:0] type_r, type_nxt;

  logic [NibW:0]    hv;
  logic [ByteW-1:0] byte_val;
  logic [ByteW-1:0] sum_add;

  assign hv       = hex_value(char_in);
  assign byte_val = {high_r, hv[NibW-1:0]};
  assign sum_add  = sum_r + byte_val;

  // Next state and event
  always_comb begin
    phase_nxt = phase_r;
    high_nxt  = high_r;
    half_nxt  = half_r;
    left_nxt  = left_r;
    addr_nxt  = addr_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    res       = '0;
    res.rkind = type_r;

    if (phase_r == PH_IDLE) begin
      if (char_in == CHAR_COLON) begin
        phase_nxt = PH_COUNT;
        high_nxt  = '0;
        half_nxt  = 1'b0;
        sum_nxt   = '0;
        type_nxt  = '0;
        left_nxt  = '0;
      end
    end else if (hv[NibW]) begin
      // Non-hex character inside a record
      phase_nxt = PH_IDLE;
      half_nxt  = 1'b0;
      res.vld   = 1'b1;
      res.kind  = EV_MALFORMED;
    end else if (!half_r) begin
      high_nxt = hv[NibW-1:0];
      half_nxt = 1'b1;
    end else begin
      half_nxt = 1'b0;
      sum_nxt  = sum_add;
      case (phase_r)
        PH_COUNT: begin
          left_nxt  = byte_val;
          phase_nxt = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          addr_nxt  = {byte_val, {(AddrW-ByteW){1'b0}}};
          phase_nxt = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          addr_nxt  = {addr_r[AddrW-1:ByteW], byte_val};
          phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          type_nxt  = byte_val;
          phase_nxt = (left_r != '0) ? PH_DATA : PH_CSUM;
        end
        PH_DATA: begin
          addr_nxt = addr_r + 1'b1;
          left_nxt = left_r - 1'b1;
          if (left_r == 8'd1) begin
            phase_nxt = PH_CSUM;
          end
          if (type_r == REC_DATA) begin
            res.vld  = 1'b1;
            res.kind = EV_WRITE;
            res.addr = addr_r;
            res.data = byte_val;
          end
        end
        PH_CSUM: begin
          phase_nxt = PH_IDLE;
          res.vld   = 1'b1;
          if (sum_add != '0) begin
            res.kind = EV_CSUM_ERR;
          end else if (type_r == REC_EOF) begin
            res.kind = EV_EOF;
          end else begin
            res.kind = EV_OK;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // State registers, updated only when a character moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      high_r  <= '0;
      half_r  <= 1'b0;
      left_r  <= '0;
      addr_r  <= '0;
      sum_r   <= '0;
      type_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      high_r  <= high_nxt;
      half_r  <= half_nxt;
      left_r  <= left_nxt;
      addr_r  <= addr_nxt;
      sum_r   <= sum_nxt;
      type_r  <= type_nxt;
    end
  end
endmodule
`default_nettype wire

>>> src/ihex_out_stage.sv
// Result register for the event request channel.
`timescale 1ns / 1ps
`default_nettype none
module ihex_out_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire ihex_pkg::ihex_res_t         res,
  output logic                             slot_free,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ihex_pkg::KindW-1:0]       out_event_kind,
  output logic [ihex_pkg::AddrW-1:0]       out_write_address,
  output logic [ihex_pkg::ByteW-1:0]       out_write_data,
  output logic [ihex_pkg::ByteW-1:0]       out_record_kind
);
  import ihex_pkg::*;

  logic             vld_r, vld_nxt;
  logic [KindW-1:0] kind_r;
  logic [AddrW-1:0] addr_r;
  logic [ByteW-1:0] data_r;
  logic [ByteW-1:0] rkind_r;

  // Slot is free when empty or being taken this cycle
  assign slot_free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = res.vld;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload loads only with a new event
  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      kind_r  <= res.kind;
      addr_r  <= res.addr;
      data_r  <= res.data;
      rkind_r <= res.rkind;
    end
  end

  assign out_valid         = vld_r;
  assign out_event_kind    = kind_r;
  assign out_write_address = addr_r;
  assign out_write_data    = data_r;
  assign out_record_kind   = rkind_r;
endmodule
`default_nettype wire

>>> src/intel_hex_record_parser_core.sv
// Path: an accepted character waits in the input register, and its event is registered in the output register.
// Throughput: one character per cycle unless a held event meets an output stall; set by the single parser state update.
// A held event stalls the input only while the output side stalls.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to idle, waiting for a colon, with all record state cleared.
// Top level of the HEX record parser.
`timescale 1ns / 1ps
`default_nettype none
module intel_hex_record_parser_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [ihex_pkg::CharW-1:0] in_char_in,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ihex_pkg::KindW-1:0]      out_event_kind,
  output logic [ihex_pkg::AddrW-1:0]      out_write_address,
  output logic [ihex_pkg::ByteW-1:0]      out_write_data,
  output logic [ihex_pkg::ByteW-1:0]      out_record_kind
);
  import ihex_pkg::*;

  logic             hold_vld;
  logic [CharW-1:0] hold_char;
  logic             slot_free;
  logic             adv;
  ihex_res_t        res;

  // Character moves on when the result slot can take its outcome
  assign adv = hold_vld && slot_free;

  ihex_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_char   (in_char_in),
    .adv       (adv),
    .hold_vld  (hold_vld),
    .hold_char (hold_char)
  );

  ihex_parser u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .char_in (hold_char),
    .res     (res)
  );

  ihex_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .res               (res),
    .slot_free         (slot_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_record_kind   (out_record_kind)
  );
endmodule
`default_nettype wire

>>> src/ihex_checker.sv
// Port-level checks for the HEX record parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ihex_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [ihex_pkg::KindW-1:0] out_event_kind,
  input wire logic [ihex_pkg::AddrW-1:0] out_write_address,
  input wire logic [ihex_pkg::ByteW-1:0] out_write_data,
  input wire logic [ihex_pkg::ByteW-1:0] out_record_kind
);
  import ihex_pkg::*;

  // Stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind) &&
      $stable(out_write_address) && $stable(out_write_data) && $stable(out_record_kind))
    else $error("stalled event changed");

  // Only defined event codes
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_kind <= EV_MALFORMED)
    else $error("undefined event code");

  // Non-write events carry zero address and data
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != EV_WRITE |->
      out_write_address == '0 && out_write_data == '0)
    else $error("status event with address or data");

  // Writes only belong to data records
  a_write_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_WRITE |-> out_record_kind == REC_DATA)
    else $error("write from a non-data record");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("event present after reset");
endmodule

bind intel_hex_record_parser_core ihex_checker u_ihex_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_event_kind    (out_event_kind),
  .out_write_address (out_write_address),
  .out_write_data    (out_write_data),
  .out_record_kind   (out_record_kind)
);
`default_nettype wire
